[hdl/cursor_text_buffer_assert.svh]
// assertion macros shared by the checker files
`ifndef CURSOR_TEXT_BUFFER_ASSERT_SVH
`define CURSOR_TEXT_BUFFER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CTB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor_text_buffer check failed");

// next-cycle implication, clocked on clk, off during reset
`define CTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor_text_buffer check failed");

`endif

[hdl/ctb_pkg.sv]
package ctb_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int COUNT_W   = 6;

    // operation codes carried in req.func; code 7 changes nothing but still gets a response
    typedef enum logic [2:0] {
        FN_FWD     = 3'd0,
        FN_BACK    = 3'd1,
        FN_START   = 3'd2,
        FN_END     = 3'd3,
        FN_INSERT  = 3'd4,
        FN_DELETE  = 3'd5,
        FN_DISPLAY = 3'd6
    } func_t;

    typedef enum logic {
        ST_EDIT,
        ST_DISPLAY
    } ctl_state_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_in;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] length_now;
        logic [COUNT_W-1:0] cursor_now;
        logic [7:0]         char_out;
        logic               char_valid;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic edit;
        logic step;
    } ctb_cmd_t;

    typedef struct packed {
        logic can_push;
        logic fill_zero;
        logic disp_last;
    } ctb_stat_t;

endpackage

[hdl/cursor_text_buffer.sv]
// Editor buffer of up to DEPTH bytes with a fill count and a cursor. Each
// request transaction is one operation (forward, back, to start, to end,
// insert, delete, display). Moves and edits give a single response
// transaction each, through the output register: every cell of the byte row
// compares its own index with the cursor and shifts left or right as the
// request is taken. Display gives one response per stored byte, one per
// cycle while responses are not stalled, after the cycle that takes the
// request. The row rotates by one cell per byte and the byte in cell 0 is
// emitted; after the last byte the row is back in its original order. An
// empty display gives one response with char_valid low. No request is
// taken during a display, and a stalled response holds the display in
// place. Responses leave through an output register backed by one skid
// entry, so a new request is still taken while one response waits. Fill
// count and cursor clear on reset; the byte row has no reset and no
// clearing pass, only bytes below the fill count are ever shown.
module cursor_text_buffer #(
    parameter int DEPTH = ctb_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    // request channel
    input  logic          req_valid,
    output logic          req_stall,
    input  ctb_pkg::req_t req,
    // response channel
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ctb_pkg::rsp_t rsp
);

    // command and status between sequencer and datapath
    ctb_pkg::ctb_cmd_t  cmd;
    ctb_pkg::ctb_stat_t stat;

    // sequencer: takes requests, walks display one byte a cycle while responses can be queued
    ctb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (req.func),
        .stat      (stat),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // byte row, counts and response queue
    ctb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[hdl/ctb_ctrl.sv]
module ctb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [2:0]           func,
    input  ctb_pkg::ctb_stat_t   stat,
    output logic                 req_stall,
    output ctb_pkg::ctb_cmd_t    cmd
);

    ctb_pkg::ctl_state_t state_reg;
    ctb_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctb_pkg::ST_EDIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctb_pkg::ST_EDIT:
            begin
                if (req_valid && stat.can_push && func == ctb_pkg::FN_DISPLAY
                    && !stat.fill_zero)
                begin
                    state_next = ctb_pkg::ST_DISPLAY;
                end
            end
            ctb_pkg::ST_DISPLAY:
            begin
                if (stat.can_push && stat.disp_last)
                begin
                    state_next = ctb_pkg::ST_EDIT;
                end
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        cmd       = '0;
        unique case (state_reg)
            ctb_pkg::ST_EDIT:
            begin
                req_stall = !stat.can_push;
                cmd.edit  = req_valid && stat.can_push;
            end
            ctb_pkg::ST_DISPLAY:
            begin
                cmd.step = stat.can_push;
            end
        endcase
    end

endmodule

[hdl/ctb_datapath.sv]
module ctb_datapath #(
    parameter int DEPTH = ctb_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctb_pkg::ctb_cmd_t    cmd,
    input  ctb_pkg::req_t        req,
    output ctb_pkg::ctb_stat_t   stat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ctb_pkg::rsp_t        rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [7:0]    cell_reg  [DEPTH];
    logic [7:0]    cell_next [DEPTH];
    logic [7:0]    up_w      [DEPTH];
    logic [7:0]    dn_w      [DEPTH];

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          do_ins, do_del, status_bit;

    ctb_pkg::rsp_t out_reg, out_next, skid_reg, skid_next, push_data;
    logic          out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic          push, drain;

    // neighbor taps of each cell, edges hold their own value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tap
        if (i == DEPTH - 1)
        begin : g_top
            assign up_w[i] = cell_reg[i];
        end
        else
        begin : g_mid_up
            assign up_w[i] = cell_reg[i+1];
        end
        if (i == 0)
        begin : g_bot
            assign dn_w[i] = cell_reg[i];
        end
        else
        begin : g_mid_dn
            assign dn_w[i] = cell_reg[i-1];
        end
    end

    // counts and cursor for the edit operations
    always_comb
    begin
        fill_next  = fill_reg;
        cur_next   = cur_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        status_bit = 1'b0;
        if (cmd.edit)
        begin
            unique case (req.func)
                ctb_pkg::FN_FWD:
                begin
                    if (cur_reg < fill_reg)
                    begin
                        cur_next = cur_reg + CW'(1);
                    end
                end
                ctb_pkg::FN_BACK:
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - CW'(1);
                    end
                end
                ctb_pkg::FN_START:
                begin
                    cur_next = '0;
                end
                ctb_pkg::FN_END:
                begin
                    cur_next = fill_reg;
                end
                ctb_pkg::FN_INSERT:
                begin
                    if (fill_reg >= CW'(DEPTH))
                    begin
                        status_bit = 1'b1;
                    end
                    else
                    begin
                        do_ins    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                        cur_next  = cur_reg + CW'(1);
                    end
                end
                ctb_pkg::FN_DELETE:
                begin
                    if (cur_reg < fill_reg)
                    begin
                        do_del    = 1'b1;
                        fill_next = fill_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // each cell picks its new byte from its index against cursor and fill
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (CW'(i) == cur_reg)
                begin
                    cell_next[i] = req.char_in;
                end
                else if (CW'(i) > cur_reg && CW'(i) <= fill_reg)
                begin
                    cell_next[i] = dn_w[i];
                end
            end
            else if (do_del)
            begin
                if (CW'(i) >= cur_reg && CW'(i + 1) < fill_reg)
                begin
                    cell_next[i] = up_w[i];
                end
            end
            else if (cmd.step)
            begin
                // rotate the stored text by one, cell 0 wraps to the top
                if (CW'(i + 1) < fill_reg)
                begin
                    cell_next[i] = up_w[i];
                end
                else if (CW'(i + 1) == fill_reg)
                begin
                    cell_next[i] = cell_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign cnt_next = cmd.edit ? '0 : (cmd.step ? cnt_reg + IW'(1) : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cur_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            cur_reg  <= cur_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result to queue
    assign push = (cmd.edit && !(req.func == ctb_pkg::FN_DISPLAY && fill_reg != '0))
                  || cmd.step;

    always_comb
    begin
        push_data = '0;
        if (cmd.step)
        begin
            push_data.length_now = ctb_pkg::COUNT_W'(fill_reg);
            push_data.cursor_now = ctb_pkg::COUNT_W'(cur_reg);
            push_data.char_out   = cell_reg[0];
            push_data.char_valid = 1'b1;
            push_data.last       = stat.disp_last;
        end
        else
        begin
            push_data.status     = status_bit;
            push_data.length_now = ctb_pkg::COUNT_W'(fill_next);
            push_data.cursor_now = ctb_pkg::COUNT_W'(cur_next);
            push_data.last       = 1'b1;
        end
    end

    // output register with one skid entry
    assign drain = out_valid_reg && !rsp_stall;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || drain)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp            = out_reg;
    assign stat.can_push  = !skid_valid_reg;
    assign stat.fill_zero = (fill_reg == '0);
    assign stat.disp_last = ((CW'(cnt_reg) + CW'(1)) == fill_reg);

endmodule

[hdl/ctb_checker.sv]
`include "cursor_text_buffer_assert.svh"

module ctb_checker #(
    parameter int DEPTH = ctb_pkg::DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ctb_pkg::rsp_t rsp
);

    // a stalled response holds
    `CTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // length never beyond the buffer size
    `CTB_ASSERT_IMPL(a_len_range, rsp_valid,
        DEPTH >= 64 || rsp.length_now <= ctb_pkg::COUNT_W'(DEPTH))

    // cursor stays inside the stored text
    `CTB_ASSERT_IMPL(a_cur_range, rsp_valid,
        DEPTH >= 64 || rsp.cursor_now <= rsp.length_now)

    // non-byte responses are single, zero and without refusal when a byte shows
    `CTB_ASSERT_IMPL(a_char_form, rsp_valid,
        (rsp.char_valid && !rsp.status) || (!rsp.char_valid && rsp.char_out == 8'd0 && rsp.last))

endmodule

bind cursor_text_buffer ctb_checker #(.DEPTH(DEPTH)) u_ctb_checker (.*);
